// ===== rtl/efw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package efw_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   localparam int unsigned REQ_DATA_BITS = 32;
   localparam int unsigned RSP_DATA_BITS = 56;
   localparam int unsigned DUR_BITS      = 32;
   localparam int unsigned OUT_IDX_BITS  = 4;
   localparam int unsigned OUT_TIME_BITS = 48;
   localparam int unsigned COUNT_BITS    = 5;

endpackage

`default_nettype wire

// ===== rtl/efw_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efw_cell #(
   parameter int unsigned TIME_BITS = 48,
   parameter int unsigned IDX_BITS  = 4,
   parameter int unsigned CELL_ID   = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [efw_pkg::COUNT_BITS-1:0]    worker_count,
   input  wire logic                              tok_valid_in,
   input  wire logic [TIME_BITS-1:0]              tok_time_in,
   input  wire logic [IDX_BITS-1:0]               tok_idx_in,
   output logic                                   tok_valid_out,
   output logic [TIME_BITS-1:0]                   tok_time_out,
   output logic [IDX_BITS-1:0]                    tok_idx_out,
   input  wire logic                              wr_en,
   input  wire logic [IDX_BITS-1:0]               wr_idx,
   input  wire logic [TIME_BITS-1:0]              wr_time
);

   localparam logic [IDX_BITS-1:0] MY_ID = IDX_BITS'(CELL_ID);

   logic [TIME_BITS-1:0] free_time_ff, free_time_in;
   logic                 tok_valid_ff, tok_valid_in_nxt;
   logic [TIME_BITS-1:0] tok_time_ff, tok_time_in_nxt;
   logic [IDX_BITS-1:0]  tok_idx_ff, tok_idx_in_nxt;
   logic                 active;
   logic                 take;

   // worker 0 always takes part; a count of zero acts as one
   assign active = (CELL_ID == 0) || (32'(worker_count) > CELL_ID);
   assign take   = active && (free_time_ff < tok_time_in);

   always_comb begin
      tok_valid_in_nxt = tok_valid_in;
      tok_time_in_nxt  = take ? free_time_ff : tok_time_in;
      tok_idx_in_nxt   = take ? MY_ID : tok_idx_in;
      free_time_in     = (wr_en && (wr_idx == MY_ID)) ? wr_time : free_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_time_ff <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         free_time_ff <= free_time_in;
         tok_valid_ff <= tok_valid_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      tok_time_ff <= tok_time_in_nxt;
      tok_idx_ff  <= tok_idx_in_nxt;
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_time_out  = tok_time_ff;
   assign tok_idx_out   = tok_idx_ff;

endmodule

`default_nettype wire

// ===== rtl/earliest_free_worker_dispatch_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An accepted job word sends a search token down the worker chain, one cell per
// cycle; the earliest free time is then captured and committed into the result
// register. A new job word is taken only after that commit, so one job is in
// flight at a time; the commit waits while the previous result word waits for its receiver.
// Reset (synchronous, active high) clears every free time to zero, sets the
// worker count to one and empties the result register.
module earliest_free_worker_dispatch_core #(
   parameter int unsigned MAX_WORKERS = 16,
   parameter int unsigned TIME_BITS   = 48
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [31:0] job_duration
   input  wire logic [efw_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [3:0] worker_index, [51:4] start_time, [55:52] zero
   output logic [efw_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [efw_pkg::COUNT_BITS-1:0]      csr_wdata
);

   localparam int unsigned IDX_BITS  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int unsigned SUM_BITS  =
      ((TIME_BITS > efw_pkg::DUR_BITS) ? TIME_BITS : efw_pkg::DUR_BITS) + 1;
   localparam int unsigned WIDE_IDX  =
      (IDX_BITS > efw_pkg::OUT_IDX_BITS) ? IDX_BITS : efw_pkg::OUT_IDX_BITS;
   localparam int unsigned WIDE_TIME =
      (TIME_BITS > efw_pkg::OUT_TIME_BITS) ? TIME_BITS : efw_pkg::OUT_TIME_BITS;
   localparam int unsigned PAD_BITS  =
      efw_pkg::RSP_DATA_BITS - efw_pkg::OUT_IDX_BITS - efw_pkg::OUT_TIME_BITS;

   efw_pkg::state_type state_ff, state_in;

   logic [efw_pkg::COUNT_BITS-1:0]    worker_count_ff, worker_count_in;
   logic [efw_pkg::DUR_BITS-1:0]      dur_ff, dur_in;
   logic [TIME_BITS-1:0]              best_time_ff, best_time_in;
   logic [IDX_BITS-1:0]               best_idx_ff, best_idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [efw_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                 tok_valid [0:MAX_WORKERS];
   logic [TIME_BITS-1:0] tok_time  [0:MAX_WORKERS];
   logic [IDX_BITS-1:0]  tok_idx   [0:MAX_WORKERS];

   logic                 req_fire;
   logic                 out_free;
   logic                 commit;
   logic [SUM_BITS-1:0]  sum;
   logic [TIME_BITS-1:0] new_time;
   logic [WIDE_IDX-1:0]  idx_wide;
   logic [WIDE_TIME-1:0] time_wide;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         efw_pkg::ST_IDLE:   if (req_fire) state_in = efw_pkg::ST_SCAN;
         efw_pkg::ST_SCAN:   if (tok_valid[MAX_WORKERS]) state_in = efw_pkg::ST_COMMIT;
         efw_pkg::ST_COMMIT: if (out_free) state_in = efw_pkg::ST_IDLE;
         default:            state_in = efw_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         efw_pkg::ST_IDLE:   req_tready = 1'b1;
         efw_pkg::ST_SCAN:   req_tready = 1'b0;
         efw_pkg::ST_COMMIT: commit     = out_free;
         default: begin
            req_tready = 1'b0;
            commit     = 1'b0;
         end
      endcase
   end

   // inject the search token at cell 0 with the largest time
   assign tok_valid[0] = req_fire;
   assign tok_time[0]  = '1;
   assign tok_idx[0]   = '0;

   for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
      efw_cell #(
         .TIME_BITS (TIME_BITS),
         .IDX_BITS  (IDX_BITS),
         .CELL_ID   (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .worker_count  (worker_count_ff),
         .tok_valid_in  (tok_valid[i]),
         .tok_time_in   (tok_time[i]),
         .tok_idx_in    (tok_idx[i]),
         .tok_valid_out (tok_valid[i+1]),
         .tok_time_out  (tok_time[i+1]),
         .tok_idx_out   (tok_idx[i+1]),
         .wr_en         (commit),
         .wr_idx        (best_idx_ff),
         .wr_time       (new_time)
      );
   end

   // saturating advance of the chosen worker
   assign sum      = SUM_BITS'(best_time_ff) + SUM_BITS'(dur_ff);
   assign new_time = (sum > SUM_BITS'({TIME_BITS{1'b1}})) ? '1 : sum[TIME_BITS-1:0];

   assign idx_wide  = WIDE_IDX'(best_idx_ff);
   assign time_wide = WIDE_TIME'(best_time_ff);

   always_comb begin
      worker_count_in = csr_we ? csr_wdata : worker_count_ff;
      dur_in          = req_fire ? req_tdata[efw_pkg::DUR_BITS-1:0] : dur_ff;
      best_time_in    = tok_valid[MAX_WORKERS] ? tok_time[MAX_WORKERS] : best_time_ff;
      best_idx_in     = tok_valid[MAX_WORKERS] ? tok_idx[MAX_WORKERS] : best_idx_ff;
      rsp_data_in     = commit ? {{PAD_BITS{1'b0}},
                                  time_wide[efw_pkg::OUT_TIME_BITS-1:0],
                                  idx_wide[efw_pkg::OUT_IDX_BITS-1:0]}
                               : rsp_data_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= efw_pkg::ST_IDLE;
         worker_count_ff <= efw_pkg::COUNT_BITS'(1);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         worker_count_ff <= worker_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff       <= dur_in;
      best_time_ff <= best_time_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/efw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efw_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [efw_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // one job at a time: busy right after accepting a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("job word accepted while a search is running");

   // a fresh result comes with the block back to idle
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result issued without returning to idle");

   // padding above start_time stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[efw_pkg::RSP_DATA_BITS-1:52] == '0))
      else $error("result padding not zero");

endmodule

bind earliest_free_worker_dispatch_core efw_checker u_efw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== verif/earliest_free_worker_dispatch_core_tb.sv =====
`timescale 1ns / 1ps

module earliest_free_worker_dispatch_core_tb;

   localparam int NUM_WORKERS = 16;
   localparam int TIME_W      = efw_pkg::OUT_TIME_BITS;
   localparam int IDX_W       = efw_pkg::OUT_IDX_BITS;
   localparam int DUR_W       = efw_pkg::DUR_BITS;
   localparam int PAD_LSB     = IDX_W + TIME_W;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_SHOWN   = 200;
   localparam int COUNT_PLAN [12] = '{16, 2, 31, 1, 5, 0, 16, 8, 17, 3, 15, 4};

   typedef struct {
      logic [IDX_W-1:0]  worker;
      logic [TIME_W-1:0] start;
   } dispatch_type;

   class worker_timeline;
      logic [TIME_W-1:0]               free_time [NUM_WORKERS];
      logic [efw_pkg::COUNT_BITS-1:0]  worker_count;
      dispatch_type                    expected_dispatches [$];
      int                              errors;
      int                              checked;
      int                              saturations;

      function void clear();
         foreach (free_time[i]) free_time[i] = '0;
         worker_count = 1;
         expected_dispatches.delete();
      endfunction

      function void set_count(logic [efw_pkg::COUNT_BITS-1:0] value);
         worker_count = value;
      endfunction

      // pick the earliest free worker, lowest id on a tie, then book the job on it
      function void note_job(logic [DUR_W-1:0] duration);
         int              active;
         int              best;
         logic [TIME_W:0] sum;
         active = worker_count;
         if (active == 0) active = 1;
         if (active > NUM_WORKERS) active = NUM_WORKERS;
         best = 0;
         for (int i = 1; i < active; i++) begin
            if (free_time[i] < free_time[best]) best = i;
         end
         expected_dispatches.push_back('{worker: best[IDX_W-1:0], start: free_time[best]});
         sum = {1'b0, free_time[best]} + duration;
         if (sum[TIME_W]) begin
            free_time[best] = TIME_MAX;
            saturations++;
         end else begin
            free_time[best] = sum[TIME_W-1:0];
         end
      endfunction

      function void report(string field, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= MAX_SHOWN) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         end
      endfunction

      function void check_dispatch(logic [efw_pkg::RSP_DATA_BITS-1:0] word);
         dispatch_type want;
         if (expected_dispatches.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
               $display("%0t: unexpected result word, expected none, actual 0x%0h", $time, word);
            end
            return;
         end
         want = expected_dispatches.pop_front();
         checked++;
         if (word[IDX_W-1:0] !== want.worker)
            report("worker_index", want.worker, word[IDX_W-1:0]);
         if (word[IDX_W +: TIME_W] !== want.start)
            report("start_time", want.start, word[IDX_W +: TIME_W]);
         if (word[efw_pkg::RSP_DATA_BITS-1:PAD_LSB] !== '0)
            report("padding", 0, word[efw_pkg::RSP_DATA_BITS-1:PAD_LSB]);
      endfunction
   endclass

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [efw_pkg::REQ_DATA_BITS-1:0]   req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [efw_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                                csr_we     = 1'b0;
   logic [efw_pkg::COUNT_BITS-1:0]      csr_wdata  = '0;

   worker_timeline timeline = new();

   int tx_max_gap       = 17;
   int rx_max_stall     = 17;
   int rx_hold          = 0;
   int settings_written = 0;

   earliest_free_worker_dispatch_core #(
      .MAX_WORKERS(NUM_WORKERS),
      .TIME_BITS(TIME_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample every handshake on the edge that commits it
   always @(posedge clock) begin
      if (reset) begin
         timeline.clear();
      end else begin
         if (csr_we) timeline.set_count(csr_wdata);
         if (rsp_tvalid && rsp_tready) timeline.check_dispatch(rsp_tdata);
         if (req_tvalid && req_tready) timeline.note_job(req_tdata);
      end
   end

   function automatic logic [DUR_W-1:0] pick_duration();
      int k;
      k = $urandom_range(0, 9);
      case (k)
         0:       return '0;
         1:       return '1;
         2, 3, 4: return $urandom_range(0, 15);
         5, 6:    return $urandom_range(0, 1000);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_job(input logic [DUR_W-1:0] duration);
      int gap;
      gap = $urandom_range(0, tx_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= duration;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (timeline.expected_dispatches.size() != 0) @(posedge clock);
      repeat (NUM_WORKERS + 4) @(posedge clock);
   endtask

   task automatic write_worker_count(input logic [efw_pkg::COUNT_BITS-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_written++;
   endtask

   // result side: random stalls per word, one long hold-off when asked
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold) @(posedge clock);
            rx_hold = 0;
         end else begin
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   initial begin
      int jobs;
      int idle;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // count of one after reset: every job lands on worker zero
      send_job('0);
      send_job('1);
      send_job(1);
      // zero count behaves as one
      write_worker_count(0);
      send_job(5);
      send_job(0);
      write_worker_count(16);
      // ties go to the lowest id
      repeat (3) send_job(0);
      send_job(7);
      send_job(7);
      send_job(3);
      // oversized counts clamp to all workers
      write_worker_count(31);
      send_job('1);
      send_job(9);
      write_worker_count(17);
      send_job(2);
      // narrowed set, dropped workers keep their times
      write_worker_count(2);
      send_job(1);
      send_job(1);
      write_worker_count(16);
      repeat (3) send_job(0);

      for (int p = 0; p < 12; p++) begin
         write_worker_count(efw_pkg::COUNT_BITS'(p == 11 ? $urandom_range(0, 31)
                                                         : COUNT_PLAN[p]));
         idle = (p % 4 == 3) ? 0 : 17;
         tx_max_gap   = idle;
         rx_max_stall = idle;
         if (p == 6) begin
            rx_hold    = HOLD_CYCLES;
            tx_max_gap = 0;
         end
         jobs = $urandom_range(50, 70);
         repeat (jobs) send_job(pick_duration());
      end

      // finish on worker zero alone, then widen to two
      write_worker_count(1);
      tx_max_gap   = 0;
      rx_max_stall = 0;
      repeat (3) send_job(pick_duration());
      write_worker_count(2);
      send_job(0);
      send_job(pick_duration());
      wait_drained();

      $display("checked %0d dispatches across %0d worker-count writes, %0d time saturations",
               timeline.checked, settings_written, timeline.saturations);
      $display("random idling on both sides plus one %0d-cycle result hold-off", HOLD_CYCLES);
      if (timeline.errors == 0 && timeline.expected_dispatches.size() == 0) begin
         $display("earliest_free_worker_dispatch_core regression: pass");
      end else begin
         $display("earliest_free_worker_dispatch_core regression: fail");
      end
      $finish;
   end

   initial begin
      #(4_000_000);
      $display("timeout with %0d results outstanding", timeline.expected_dispatches.size());
      $display("earliest_free_worker_dispatch_core regression: fail");
      $finish;
   end

endmodule
